// ----- rtl/rpa_pkg.sv -----
// ----------------------------------------------------------------------------
// rpa_pkg: shared definitions for the reference-counted page allocator
// Sizes, field widths, request and status codes, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

   // Geometry of the managed region
   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_SIZE  = 4096;
   localparam int COUNT_BITS = 8;

   localparam int ADDR_W     = 56;
   localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
   localparam int IDX_W      = $clog2(NUM_PAGES);      // page index
   localparam int PCNT_W     = IDX_W + 1;              // 0 .. NUM_PAGES
   localparam int RB_W       = ADDR_W + 1;             // rounded base may reach 2^56
   localparam int DIFF_W     = ADDR_W + 2;             // signed difference
   localparam int OFF_W      = RB_W - PAGE_SHIFT;      // page offset from base

   localparam int FUNC_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 1;

   // Register reset values
   localparam logic [ADDR_W-1:0] REGION_BASE_RST  = ADDR_W'(64'd2147483648);
   localparam logic [ADDR_W-1:0] REGION_LIMIT_RST = ADDR_W'(64'd2281701376);
   localparam logic [RB_W-1:0]   ROUNDED_BASE_RST =
      ((RB_W'(REGION_BASE_RST) + RB_W'(PAGE_SIZE - 1)) >> PAGE_SHIFT) << PAGE_SHIFT;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LIMIT = 1'b1;

   // Request kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_INIT  = 2'd2
   } func_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_OUT_OF_MEM = 3'd1,
      STATUS_BAD_ADDR   = 3'd2,
      STATUS_DBL_FREE   = 3'd3,
      STATUS_CNT_NZ     = 3'd4
   } status_type;

   // Controller to datapath strobes
   typedef struct packed {
      logic capture;      // take the request word
      logic prep;         // work out page count and free offset, clear result
      logic alloc_pop;    // pop the stack top
      logic alloc_read;   // read the count of the popped page
      logic alloc_upd;    // grant or reject the popped page
      logic free_chk;     // range check, read the count of the freed page
      logic free_upd;     // decrement, push when released
      logic sweep_en;     // walk every page, clearing its count
      logic sweep_stack;  // during the walk, also lay pages on the stack
      logic res_load;     // move the result into the output register
   } cmd_type;

   // Datapath to controller flags
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              stack_empty;
      logic              sweep_last;
      logic              rsp_free;
   } stat_type;

endpackage

// ----- rtl/refcounted_page_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_page_allocator: physical page allocator with reference counts
// LIFO free stack of page indexes plus a per-page count memory, driven by a
// small sequencer.
// ----------------------------------------------------------------------------
// One request is in work at a time. An allocate does a registered read of the
// stack memory, then of the count memory for the popped page, and sets that
// count when it is zero; with the stack empty it goes straight to the result.
// A free reads the count memory, registered, and writes back the decremented
// count, pushing a page it releases. An initialise walks every page slot, one
// per cycle. After reset the block clears the count memory likewise before
// it raises req_ready; configuration writes are taken at any time, always ready.
// A finished word sits in the output register, so the next request is accepted
// while it waits to be taken. Page addresses are rebuilt from the current
// region registers; the base is rounded up to a whole page when written.
module refcounted_page_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [rpa_pkg::FUNC_W-1:0]      req_func,
   input  logic [rpa_pkg::ADDR_W-1:0]      req_page_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rpa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic                            rsp_still_referenced,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpa_pkg::ADDR_W-1:0]      csr_wdata
);
   import rpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   rpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rpa_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_func             (req_func),
      .req_page_address     (req_page_address),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_granted_address  (rsp_granted_address),
      .rsp_still_referenced (rsp_still_referenced)
   );

endmodule

// ----- rtl/rpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpa_ctrl: request sequencer
// One-hot state machine that steps each request through the datapath and
// runs the count clearing walk after reset.
// ----------------------------------------------------------------------------
module rpa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rpa_pkg::stat_type stat,
   output rpa_pkg::cmd_type  cmd
);
   import rpa_pkg::*;

   typedef enum logic [10:0] {
      S_CLEAR      = 11'b000_0000_0001,
      S_IDLE       = 11'b000_0000_0010,
      S_PREP       = 11'b000_0000_0100,
      S_ALLOC_POP  = 11'b000_0000_1000,
      S_ALLOC_READ = 11'b000_0001_0000,
      S_ALLOC_UPD  = 11'b000_0010_0000,
      S_FREE_CHK   = 11'b000_0100_0000,
      S_FREE_UPD   = 11'b000_1000_0000,
      S_INIT_SWEEP = 11'b001_0000_0000,
      S_RESULT     = 11'b010_0000_0000,
      S_SPARE      = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state and command strobes
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.sweep_en = 1'b1;
            if (stat.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            unique case (stat.func)
               FUNC_ALLOC: state_in = S_ALLOC_POP;
               FUNC_FREE:  state_in = S_FREE_CHK;
               FUNC_INIT:  state_in = S_INIT_SWEEP;
               default:    state_in = S_RESULT;
            endcase
         end
         S_ALLOC_POP: begin
            cmd.alloc_pop = 1'b1;
            state_in      = stat.stack_empty ? S_RESULT : S_ALLOC_READ;
         end
         S_ALLOC_READ: begin
            cmd.alloc_read = 1'b1;
            state_in       = S_ALLOC_UPD;
         end
         S_ALLOC_UPD: begin
            cmd.alloc_upd = 1'b1;
            state_in      = S_RESULT;
         end
         S_FREE_CHK: begin
            cmd.free_chk = 1'b1;
            state_in     = S_FREE_UPD;
         end
         S_FREE_UPD: begin
            cmd.free_upd = 1'b1;
            state_in     = S_RESULT;
         end
         S_INIT_SWEEP: begin
            cmd.sweep_en    = 1'b1;
            cmd.sweep_stack = 1'b1;
            if (stat.sweep_last) state_in = S_RESULT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/rpa_dpath.sv -----
// ----------------------------------------------------------------------------
// rpa_dpath: allocator datapath
// Region registers, free stack and count memories, address arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module rpa_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  rpa_pkg::cmd_type                cmd,
   output rpa_pkg::stat_type               stat,
   input  logic [rpa_pkg::FUNC_W-1:0]      req_func,
   input  logic [rpa_pkg::ADDR_W-1:0]      req_page_address,
   input  logic                            csr_valid,
   input  logic [rpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rpa_pkg::ADDR_W-1:0]      csr_wdata,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [rpa_pkg::STATUS_W-1:0]    rsp_status,
   output logic [rpa_pkg::ADDR_W-1:0]      rsp_granted_address,
   output logic                            rsp_still_referenced
);
   import rpa_pkg::*;

   // Memories
   logic [IDX_W-1:0]      stack_mem [NUM_PAGES];
   logic [COUNT_BITS-1:0] cnt_mem   [NUM_PAGES];

   // Registers
   logic [RB_W-1:0]       rbase_ff, rbase_in;
   logic [ADDR_W-1:0]     limit_ff, limit_in;
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [PCNT_W-1:0]     npages_ff, npages_in;
   logic [OFF_W-1:0]      off_page_ff, off_page_in;
   logic                  off_ok_ff, off_ok_in;
   logic                  ok_ff, ok_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [PCNT_W-1:0]     top_ff, top_in;
   logic [IDX_W-1:0]      sweep_ff, sweep_in;
   logic [IDX_W-1:0]      stack_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [ADDR_W-1:0]     res_granted_ff, res_granted_in;
   logic                  res_still_ff, res_still_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [ADDR_W-1:0]     rsp_granted_ff;
   logic                  rsp_still_ff;

   // Combinational helpers
   logic [RB_W-1:0]       wdata_round;
   logic [DIFF_W-1:0]     lim_diff, addr_diff;
   logic [OFF_W-1:0]      lim_pages;
   logic [PCNT_W-1:0]     top_dec;
   logic [RB_W-1:0]       grant_sum;
   logic [COUNT_BITS-1:0] cnt_dec;
   logic                  stack_full, cnt_zero, push;
   logic                  stk_we, cnt_we;
   logic [IDX_W-1:0]      stk_waddr, stk_wdata, stk_raddr;
   logic [IDX_W-1:0]      cnt_waddr, cnt_raddr;
   logic [COUNT_BITS-1:0] cnt_wdata;

   // Region arithmetic
   assign wdata_round = ((RB_W'(csr_wdata) + RB_W'(PAGE_SIZE - 1)) >> PAGE_SHIFT) << PAGE_SHIFT;
   assign lim_diff    = DIFF_W'(limit_ff) - DIFF_W'(rbase_ff);
   assign addr_diff   = DIFF_W'(addr_ff) - DIFF_W'(rbase_ff);
   assign lim_pages   = lim_diff[RB_W-1:PAGE_SHIFT];
   assign top_dec     = top_ff - PCNT_W'(1);
   assign grant_sum   = rbase_ff + (RB_W'(idx_ff) << PAGE_SHIFT);
   assign cnt_dec     = cnt_rd_ff - COUNT_BITS'(1);
   assign stack_full  = (top_ff == PCNT_W'(NUM_PAGES));
   assign cnt_zero    = (cnt_rd_ff == '0);
   assign push        = cmd.free_upd && ok_ff && !cnt_zero && (cnt_dec == '0);

   // Status to the controller
   assign stat.func        = func_ff;
   assign stat.stack_empty = (top_ff == '0);
   assign stat.sweep_last  = (sweep_ff == '1);
   assign stat.rsp_free    = !rsp_valid_ff || rsp_ready;

   // Memory port selection
   always_comb begin
      stk_we    = 1'b0;
      stk_waddr = sweep_ff;
      stk_wdata = sweep_ff;
      if (cmd.sweep_en) begin
         stk_we = cmd.sweep_stack && (PCNT_W'(sweep_ff) < npages_ff);
      end else if (push && !stack_full) begin
         stk_we    = 1'b1;
         stk_waddr = top_ff[IDX_W-1:0];
         stk_wdata = idx_ff;
      end
      stk_raddr = top_dec[IDX_W-1:0];

      cnt_we    = 1'b0;
      cnt_waddr = idx_ff;
      cnt_wdata = '0;
      if (cmd.sweep_en) begin
         cnt_we    = 1'b1;
         cnt_waddr = sweep_ff;
      end else if (cmd.alloc_upd && cnt_zero) begin
         cnt_we    = 1'b1;
         cnt_wdata = COUNT_BITS'(1);
      end else if (cmd.free_upd && ok_ff && !cnt_zero) begin
         cnt_we    = 1'b1;
         cnt_wdata = cnt_dec;
      end
      cnt_raddr = cmd.alloc_read ? stack_rd_ff : off_page_ff[IDX_W-1:0];
   end

   // Free stack
   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
      stack_rd_ff <= stack_mem[stk_raddr];
   end

   // Reference counts
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   // Next values
   always_comb begin
      rbase_in       = rbase_ff;
      limit_in       = limit_ff;
      func_in        = func_ff;
      addr_in        = addr_ff;
      npages_in      = npages_ff;
      off_page_in    = off_page_ff;
      off_ok_in      = off_ok_ff;
      ok_in          = ok_ff;
      idx_in         = idx_ff;
      top_in         = top_ff;
      sweep_in       = cmd.sweep_en ? sweep_ff + IDX_W'(1) : sweep_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_still_in   = res_still_ff;

      // configuration writes
      if (csr_valid) begin
         if (csr_index == CSR_REGION_BASE)  rbase_in = wdata_round;
         if (csr_index == CSR_REGION_LIMIT) limit_in = csr_wdata;
      end

      if (cmd.capture) begin
         func_in = req_func;
         addr_in = req_page_address;
      end

      // page count of the region and offset of the address to free
      if (cmd.prep) begin
         if (lim_diff[DIFF_W-1])                   npages_in = '0;
         else if (lim_pages > OFF_W'(NUM_PAGES))   npages_in = PCNT_W'(NUM_PAGES);
         else                                      npages_in = lim_pages[PCNT_W-1:0];
         off_page_in    = addr_diff[RB_W-1:PAGE_SHIFT];
         off_ok_in      = (addr_ff[PAGE_SHIFT-1:0] == '0) && !addr_diff[DIFF_W-1];
         res_status_in  = STATUS_OK;
         res_granted_in = '0;
         res_still_in   = 1'b0;
      end

      if (cmd.alloc_pop) begin
         if (top_ff == '0) res_status_in = STATUS_OUT_OF_MEM;
         else              top_in        = top_dec;
      end

      if (cmd.alloc_read) idx_in = stack_rd_ff;

      if (cmd.alloc_upd) begin
         if (!cnt_zero) res_status_in  = STATUS_CNT_NZ;
         else           res_granted_in = grant_sum[ADDR_W-1:0];
      end

      if (cmd.free_chk) begin
         ok_in  = off_ok_ff && (off_page_ff < OFF_W'(npages_ff));
         idx_in = off_page_ff[IDX_W-1:0];
      end

      if (cmd.free_upd) begin
         if (!ok_ff)        res_status_in = STATUS_BAD_ADDR;
         else if (cnt_zero) res_status_in = STATUS_DBL_FREE;
         else               res_still_in  = (cnt_dec != '0);
         if (push && !stack_full) top_in = top_ff + PCNT_W'(1);
      end

      // stack holds every managed page once the walk ends
      if (cmd.sweep_en && cmd.sweep_stack && (sweep_ff == '1)) top_in = npages_ff;
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load)  rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rbase_ff     <= ROUNDED_BASE_RST;
         limit_ff     <= REGION_LIMIT_RST;
         top_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rbase_ff     <= rbase_in;
         limit_ff     <= limit_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      addr_ff        <= addr_in;
      npages_ff      <= npages_in;
      off_page_ff    <= off_page_in;
      off_ok_ff      <= off_ok_in;
      ok_ff          <= ok_in;
      idx_ff         <= idx_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_still_ff   <= res_still_in;
      if (cmd.res_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= res_granted_ff;
         rsp_still_ff   <= res_still_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_granted_address  = rsp_granted_ff;
   assign rsp_still_referenced = rsp_still_ff;

endmodule
